// ----- hw/rtl/spd_pkg.sv -----
// shared types, codes and constants for the sensor packet deframer
// no dependencies; imported by spd_parser and sensor_packet_deframer_top

package spd_pkg;

  localparam int unsigned MAX_LENGTH = 256;

  localparam logic [7:0] HDR0 = 8'hEF;
  localparam logic [7:0] HDR1 = 8'h01;

  localparam logic [2:0] KIND_CODE = 3'd0;
  localparam logic [2:0] KIND_DATA = 3'd1;
  localparam logic [2:0] KIND_GOOD = 3'd2;
  localparam logic [2:0] KIND_CSUM = 3'd3;
  localparam logic [2:0] KIND_FMT  = 3'd4;

  typedef enum logic [3:0] {
    PH_HUNT = 4'd0,
    PH_HDR2 = 4'd1,
    PH_ADDR = 4'd2,
    PH_FLAG = 4'd3,
    PH_LENH = 4'd4,
    PH_LENL = 4'd5,
    PH_CODE = 4'd6,
    PH_DATA = 4'd7,
    PH_SUMH = 4'd8,
    PH_SUML = 4'd9
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [1:0]  address_count;
    logic [15:0] bytes_left;
    logic [15:0] running_sum;
    logic [7:0]  sum_high;
    logic [7:0]  flag_seen;
    logic        address_ok;
  } parse_state_t;

  typedef struct packed {
    logic       emit;
    logic [2:0] kind;
    logic [7:0] value;
    logic [7:0] flag;
    logic       last;
  } parse_result_t;

endpackage

// ----- hw/rtl/spd_parser.sv -----
// per-byte framing logic: next parser state and the result of one beat
// depends on spd_pkg

module spd_parser (
  input  spd_pkg::parse_state_t  st,
  input  logic [7:0]             rx_byte,
  input  logic [31:0]            device_address,
  output spd_pkg::parse_state_t  st_next,
  output spd_pkg::parse_result_t res
);
  import spd_pkg::*;

  localparam logic [15:0] LEN_MIN = 16'd3;
  localparam logic [15:0] LEN_MAX = 16'(MAX_LENGTH);

  logic [7:0]  want;
  logic [15:0] len;
  logic [15:0] left_dec;
  logic        addr_ok_now;

  always_comb begin
    case (st.address_count)
      2'd0:    want = device_address[31:24];
      2'd1:    want = device_address[23:16];
      2'd2:    want = device_address[15:8];
      default: want = device_address[7:0];
    endcase
  end

  assign len         = {st.sum_high, rx_byte};
  assign left_dec    = (st.bytes_left != 16'd0) ? st.bytes_left - 16'd1 : 16'd0;
  assign addr_ok_now = st.address_ok && (rx_byte == want);

  always_comb begin
    st_next   = st;
    res.emit  = 1'b0;
    res.kind  = KIND_CODE;
    res.value = 8'd0;
    res.last  = 1'b0;
    case (st.phase)
      PH_HDR2: begin
        if (rx_byte == HDR1) begin
          st_next.phase         = PH_ADDR;
          st_next.address_count = 2'd0;
          st_next.address_ok    = 1'b1;
        end else begin
          if (rx_byte == HDR0) begin
            st_next.phase         = PH_HDR2;
            st_next.address_count = 2'd0;
            st_next.bytes_left    = 16'd0;
            st_next.running_sum   = 16'd0;
            st_next.sum_high      = 8'd0;
            st_next.flag_seen     = 8'd0;
            st_next.address_ok    = 1'b1;
          end else begin
            st_next.phase = PH_HUNT;
          end
          res.emit = 1'b1;
          res.kind = KIND_FMT;
          res.last = 1'b1;
        end
      end
      PH_ADDR: begin
        st_next.address_ok    = addr_ok_now;
        st_next.address_count = st.address_count + 2'd1;
        if (st.address_count == 2'd3) begin
          if (!addr_ok_now) begin
            st_next.phase = PH_HUNT;
            res.emit      = 1'b1;
            res.kind      = KIND_FMT;
            res.last      = 1'b1;
          end else begin
            st_next.phase = PH_FLAG;
          end
        end
      end
      PH_FLAG: begin
        st_next.flag_seen   = rx_byte;
        st_next.running_sum = {8'd0, rx_byte};
        st_next.phase       = PH_LENH;
      end
      PH_LENH: begin
        st_next.running_sum = st.running_sum + {8'd0, rx_byte};
        st_next.sum_high    = rx_byte;
        st_next.phase       = PH_LENL;
      end
      PH_LENL: begin
        st_next.running_sum = st.running_sum + {8'd0, rx_byte};
        if (len < LEN_MIN || len > LEN_MAX) begin
          st_next.phase = PH_HUNT;
          res.emit      = 1'b1;
          res.kind      = KIND_FMT;
          res.last      = 1'b1;
        end else begin
          st_next.bytes_left = len - 16'd2;
          st_next.phase      = PH_CODE;
        end
      end
      PH_CODE, PH_DATA: begin
        st_next.running_sum = st.running_sum + {8'd0, rx_byte};
        st_next.bytes_left  = left_dec;
        st_next.phase       = (left_dec == 16'd0) ? PH_SUMH : PH_DATA;
        res.emit            = 1'b1;
        res.kind            = (st.phase == PH_CODE) ? KIND_CODE : KIND_DATA;
        res.value           = rx_byte;
      end
      PH_SUMH: begin
        st_next.sum_high = rx_byte;
        st_next.phase    = PH_SUML;
      end
      PH_SUML: begin
        st_next.phase = PH_HUNT;
        res.emit      = 1'b1;
        res.kind      = ({st.sum_high, rx_byte} == st.running_sum) ? KIND_GOOD : KIND_CSUM;
        res.last      = 1'b1;
      end
      default: begin
        if (rx_byte == HDR0) begin
          st_next.phase         = PH_HDR2;
          st_next.address_count = 2'd0;
          st_next.bytes_left    = 16'd0;
          st_next.running_sum   = 16'd0;
          st_next.sum_high      = 8'd0;
          st_next.flag_seen     = 8'd0;
          st_next.address_ok    = 1'b1;
        end else begin
          st_next.phase = PH_HUNT;
        end
      end
    endcase
    res.flag = st_next.flag_seen;
  end

endmodule

// ----- hw/rtl/sensor_packet_deframer_top.sv -----
// sensor packet deframer top level: input register, parser state, result register
// depends on spd_pkg and spd_parser

// Takes one sensor-link byte per cycle when the result side keeps up: a byte
// is captured in the input register, parsed in the following cycle against
// the held framing state, and any result lands in the result register when
// the held byte advances. Bytes that give no result (header, address, flag,
// length, checksum-high) never wait on the result side. rx_stall rises only
// while a held byte has a result to hand over and the result register is full
// and stalled. device_address is written over its own valid/ready port, always
// ready, and should change only between packets.

module sensor_packet_deframer_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        rx_valid,
  output logic        rx_stall,
  input  logic [7:0]  rx_byte,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] device_address,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [2:0]  result_kind,
  output logic [7:0]  result_value,
  output logic [7:0]  packet_flag,
  output logic        last
);
  import spd_pkg::*;

  logic          rx_full;
  logic [7:0]    rx_held;
  logic [31:0]   address;
  parse_state_t  st;
  parse_state_t  st_next;
  parse_result_t pres;
  logic          res_free;
  logic          advance;

  assign cfg_ready = 1'b1;
  assign res_free  = !res_valid || !res_stall;
  assign advance   = rx_full && (res_free || !pres.emit);
  assign rx_stall  = rx_full && !advance;

  spd_parser u_parser (
    .st             (st),
    .rx_byte        (rx_held),
    .device_address (address),
    .st_next        (st_next),
    .res            (pres)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      address <= 32'hFFFF_FFFF;
    end else if (cfg_valid && cfg_ready) begin
      address <= device_address;
    end
  end

  // input beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      rx_full <= 1'b0;
    end else if (rx_valid && !rx_stall) begin
      rx_full <= 1'b1;
    end else if (advance) begin
      rx_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_valid && !rx_stall) begin
      rx_held <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase         <= PH_HUNT;
      st.address_count <= 2'd0;
      st.bytes_left    <= 16'd0;
      st.running_sum   <= 16'd0;
      st.sum_high      <= 8'd0;
      st.flag_seen     <= 8'd0;
      st.address_ok    <= 1'b1;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance && pres.emit) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && pres.emit) begin
      result_kind  <= pres.kind;
      result_value <= pres.value;
      packet_flag  <= pres.flag;
      last         <= pres.last;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (last == (result_kind == KIND_GOOD || result_kind == KIND_CSUM ||
                            result_kind == KIND_FMT)))
    else $error("last does not match result kind");

  assert property (@(posedge clk) disable iff (rst)
    res_valid && (result_kind == KIND_GOOD || result_kind == KIND_CSUM ||
                  result_kind == KIND_FMT) |-> result_value == 8'd0)
    else $error("status beat carries a nonzero value");

  assert property (@(posedge clk) disable iff (rst)
    rx_stall |-> rx_full && res_valid && res_stall)
    else $error("input stalled without a blocked result");

  assert property (@(posedge clk)
    $past(rst) |-> st.phase == PH_HUNT && !res_valid && !rx_full)
    else $error("parser not idle after reset");

endmodule
